/* rtl/core/lehrng_pkg.sv */
// Package for the multi-stream Lehmer generator: command codes, constants,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lehrng_pkg;

   localparam int unsigned VAL_W = 31;
   localparam int unsigned MUL_W = 16;
   localparam int unsigned PROD_W = VAL_W + MUL_W;

   localparam logic [VAL_W-1:0] LEH_MOD     = 31'd2147483647;
   localparam logic [MUL_W-1:0] LEH_MUL     = 16'd48271;
   localparam logic [MUL_W-1:0] LEH_JUMP    = 16'd22925;
   localparam logic [MUL_W-1:0] LEH_ONE     = 16'd1;
   localparam logic [VAL_W-1:0] LEH_DEFAULT = 31'd123456789;

   typedef enum logic [1:0] {
      CMD_DRAW  = 2'd0,
      CMD_PUT   = 2'd1,
      CMD_PLANT = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MUL_ONE  = 2'd0,
      MUL_DRAW = 2'd1,
      MUL_JUMP = 2'd2
   } mul_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_PL_START,
      ST_PL_MUL,
      ST_PL_FOLD,
      ST_PL_DONE,
      ST_OP_RD,
      ST_OP_MUL,
      ST_OP_FOLD,
      ST_OP_PUT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic        capture;
      logic        plant_init;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        mul_src_plant;
      logic        plant_step;
      logic        op_commit;
      logic        put_commit;
      logic        plant_result;
      logic        load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    auto_plant;
      logic    seed_zero;
      logic    plant_last;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/core/lehrng_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lehrng_ram #(
   parameter int unsigned WIDTH = 31,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/core/lehrng_ctrl.sv */
// Controller state machine for the multi-stream Lehmer generator.
// Depends on lehrng_pkg; drives lehrng_dp through ctrl_cmd_type.
`timescale 1ns / 1ps
`default_nettype none

module lehrng_ctrl
   import lehrng_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in          = state_ff;
      cmd               = '0;
      cmd.mul_sel       = MUL_ONE;
      req_ready         = 1'b0;
      rsp_valid_in      = rsp_valid_ff & ~rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.cmd == CMD_PLANT) begin
               state_in = status.seed_zero ? ST_PL_DONE : ST_PL_START;
            end else if (status.auto_plant) begin
               state_in = ST_PL_START;
            end else if (status.cmd == CMD_PUT) begin
               state_in = ST_OP_PUT;
            end else begin
               state_in = ST_OP_RD;
            end
         end
         ST_PL_START: begin
            cmd.plant_init = 1'b1;
            state_in       = ST_PL_MUL;
         end
         ST_PL_MUL: begin
            cmd.mul_en        = 1'b1;
            cmd.mul_src_plant = 1'b1;
            cmd.mul_sel       = MUL_JUMP;
            state_in          = ST_PL_FOLD;
         end
         ST_PL_FOLD: begin
            cmd.plant_step = 1'b1;
            if (!status.plant_last) begin
               state_in = ST_PL_MUL;
            end else if (status.cmd == CMD_PLANT) begin
               state_in = ST_PL_DONE;
            end else if (status.cmd == CMD_PUT) begin
               state_in = ST_OP_PUT;
            end else begin
               state_in = ST_OP_RD;
            end
         end
         ST_PL_DONE: begin
            cmd.plant_result = 1'b1;
            state_in         = ST_RESP;
         end
         ST_OP_RD: begin
            state_in = ST_OP_MUL;
         end
         ST_OP_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = (status.cmd == CMD_DRAW) ? MUL_DRAW : MUL_ONE;
            state_in    = ST_OP_FOLD;
         end
         ST_OP_FOLD: begin
            cmd.op_commit = 1'b1;
            state_in      = ST_RESP;
         end
         ST_OP_PUT: begin
            cmd.put_commit = 1'b1;
            state_in       = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/core/lehrng_dp.sv */
// Datapath for the multi-stream Lehmer generator: request registers, 31x16
// multiplier with modular fold, plant chain, stream state RAM and result registers.
// Depends on lehrng_pkg and lehrng_ram.
`timescale 1ns / 1ps
`default_nettype none

module lehrng_dp
   import lehrng_pkg::*;
#(
   parameter int unsigned NUM_STREAMS = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [1:0]        req_cmd,
   input  wire logic [7:0]        req_stream_index,
   input  wire logic [VAL_W-1:0]  req_seed_value,
   output logic      [VAL_W-1:0]  rsp_value,
   output logic                   rsp_status,
   input  wire ctrl_cmd_type      cmd,
   output dp_status_type          status
);

   localparam int unsigned IDX_W = $clog2(NUM_STREAMS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_STREAMS - 1);

   cmd_type           cmd_ff, cmd_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [VAL_W-1:0]  seed_ff, seed_in;
   logic              planted_ff, planted_in;
   logic [VAL_W-1:0]  s0_ff, s0_in;
   logic [VAL_W-1:0]  x_ff, x_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [VAL_W-1:0]  res_value_ff, res_value_in;
   logic              res_status_ff, res_status_in;
   logic [VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic              rsp_status_ff, rsp_status_in;

   logic [19:0]       idx_rem;
   logic [VAL_W-1:0]  operand;
   logic [VAL_W-1:0]  mul_a;
   logic [MUL_W-1:0]  mul_b;
   logic [VAL_W:0]    fold_sum;
   logic [VAL_W-1:0]  fold;
   logic [VAL_W-1:0]  plant_seed;
   logic              seed_zero;
   logic              ram_we;
   logic [IDX_W-1:0]  ram_addr;
   logic [VAL_W-1:0]  ram_wdata;
   logic [VAL_W-1:0]  ram_rdata;

   lehrng_ram #(
      .WIDTH (VAL_W),
      .DEPTH (NUM_STREAMS)
   ) u_state_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // stream index modulo NUM_STREAMS by restoring subtraction
   always_comb begin
      idx_rem = {12'd0, req_stream_index};
      for (int k = 7; k >= 0; k--) begin
         if (idx_rem >= 20'(NUM_STREAMS << k)) begin
            idx_rem = idx_rem - 20'(NUM_STREAMS << k);
         end
      end
   end

   assign seed_zero  = (seed_ff == '0);
   assign plant_seed = (cmd_ff == CMD_PLANT) ? seed_ff : LEH_DEFAULT;
   // before the first plant only stream 0 is reachable, held in s0_ff
   assign operand    = planted_ff ? ram_rdata : s0_ff;
   assign mul_a      = cmd.mul_src_plant ? x_ff : operand;

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_DRAW: mul_b = LEH_MUL;
         MUL_JUMP: mul_b = LEH_JUMP;
         MUL_ONE:  mul_b = LEH_ONE;
         default:  mul_b = LEH_ONE;
      endcase
   end

   assign prod_in  = PROD_W'(mul_a) * PROD_W'(mul_b);

   // 2^31 == 1 mod 2^31-1
   assign fold_sum = {1'b0, prod_ff[VAL_W-1:0]} + (VAL_W+1)'(prod_ff[PROD_W-1:VAL_W]);
   assign fold     = (fold_sum >= {1'b0, LEH_MOD}) ?
                     VAL_W'(fold_sum - {1'b0, LEH_MOD}) : fold_sum[VAL_W-1:0];

   always_comb begin
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      seed_in       = seed_ff;
      planted_in    = planted_ff;
      s0_in         = s0_ff;
      x_in          = x_ff;
      j_in          = j_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_addr      = idx_ff;
      ram_wdata     = fold;

      if (cmd.capture) begin
         cmd_in  = cmd_type'(req_cmd);
         idx_in  = idx_rem[IDX_W-1:0];
         seed_in = (req_seed_value == LEH_MOD) ? '0 : req_seed_value;
      end
      if (cmd.plant_init) begin
         planted_in = 1'b1;
         x_in       = plant_seed;
         j_in       = IDX_W'(1);
         ram_we     = 1'b1;
         ram_addr   = '0;
         ram_wdata  = plant_seed;
      end
      if (cmd.plant_step) begin
         x_in     = fold;
         j_in     = j_ff + IDX_W'(1);
         ram_we   = 1'b1;
         ram_addr = j_ff;
      end
      if (cmd.op_commit) begin
         res_value_in  = fold;
         res_status_in = 1'b0;
         if (cmd_ff == CMD_DRAW) begin
            if (planted_ff) begin
               ram_we = 1'b1;
            end else begin
               s0_in = fold;
            end
         end
      end
      if (cmd.put_commit) begin
         res_value_in  = '0;
         res_status_in = seed_zero;
         ram_wdata     = seed_ff;
         if (!seed_zero) begin
            if (planted_ff) begin
               ram_we = 1'b1;
            end else begin
               s0_in = seed_ff;
            end
         end
      end
      if (cmd.plant_result) begin
         res_value_in  = '0;
         res_status_in = seed_zero;
      end
      if (cmd.load_rsp) begin
         rsp_value_in  = res_value_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         planted_ff <= 1'b0;
         s0_ff      <= LEH_DEFAULT;
      end else begin
         planted_ff <= planted_in;
         s0_ff      <= s0_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      seed_ff       <= seed_in;
      x_ff          <= x_in;
      j_ff          <= j_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign status.cmd        = cmd_ff;
   assign status.auto_plant = ~planted_ff & (idx_ff != '0);
   assign status.seed_zero  = seed_zero;
   assign status.plant_last = (j_ff == LAST_IDX);

   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

/* rtl/core/multi_stream_lehmer_rng.sv */
// From accept to rsp_valid: draw/read pass dispatch, RAM read, multiply, fold, response;
// put passes dispatch, put, response; plant writes stream 0, then per further stream a
// registered 31x16 multiply and fold on a single-port state RAM, skipped for a rejected
// seed; an automatic plant goes first if needed. req_ready is high only while idle,
// even if a result is still waiting. Reset: controller idle, planted flag clear,
// stream 0 held in a register at 123456789 until the first plant; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module multi_stream_lehmer_rng
   import lehrng_pkg::*;
#(
   parameter int unsigned NUM_STREAMS = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [1:0]       req_cmd,
   input  wire logic [7:0]       req_stream_index,
   input  wire logic [VAL_W-1:0] req_seed_value,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic      [VAL_W-1:0] rsp_value,
   output logic                  rsp_status
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   lehrng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lehrng_dp #(
      .NUM_STREAMS (NUM_STREAMS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_cmd),
      .req_stream_index (req_stream_index),
      .req_seed_value   (req_seed_value),
      .rsp_value        (rsp_value),
      .rsp_status       (rsp_status),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire

/* tb/tb_multi_stream_lehmer_rng.sv */
// Self-checking testbench for multi_stream_lehmer_rng: a queue-fed driver, a response
// monitor and an in-bench model of the per-stream Lehmer states with the planting rules.
// Depends on lehrng_pkg and the multi_stream_lehmer_rng RTL.
`timescale 1ns / 1ps

module tb_multi_stream_lehmer_rng;
   import lehrng_pkg::*;

   localparam int unsigned NUM_STREAMS = 256;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PHASE_ITEMS = 310;

   typedef struct packed {
      cmd_type          cmd;
      logic [7:0]       idx;
      logic [VAL_W-1:0] seed;
      logic             drain;
   } lehmer_req_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             status;
   } lehmer_rsp_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [1:0]       req_cmd = CMD_DRAW;
   logic [7:0]       req_stream_index = 8'd0;
   logic [VAL_W-1:0] req_seed_value = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [VAL_W-1:0] rsp_value;
   logic             rsp_status;

   lehmer_req_type pending_reqs[$];
   lehmer_rsp_type rsp_expect[$];
   lehmer_req_type drive_item;
   lehmer_req_type taken_item;
   lehmer_rsp_type got_expect;

   logic [VAL_W-1:0] lehmer_states[NUM_STREAMS];
   logic             streams_planted;

   int unsigned req_sent = 0;
   int unsigned req_taken = 0;
   int unsigned err_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   multi_stream_lehmer_rng #(
      .NUM_STREAMS(NUM_STREAMS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_stream_index(req_stream_index),
      .req_seed_value(req_seed_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_value(rsp_value),
      .rsp_status(rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [VAL_W-1:0] mod_mul(logic [VAL_W-1:0] a, logic [MUL_W-1:0] m);
      logic [63:0] prod;
      prod = {33'd0, a} * {48'd0, m};
      return VAL_W'(prod % {33'd0, LEH_MOD});
   endfunction

   function automatic logic [VAL_W-1:0] seed_reduce(logic [VAL_W-1:0] seed);
      return (seed == LEH_MOD) ? '0 : seed;
   endfunction

   // fills every stream from the seed by the jump multiplier; refuses a zero seed
   function automatic logic plant_streams(logic [VAL_W-1:0] seed);
      logic [VAL_W-1:0] x;
      x = seed_reduce(seed);
      if (x == '0) return 1'b0;
      streams_planted = 1'b1;
      lehmer_states[0] = x;
      for (int j = 1; j < NUM_STREAMS; j++)
         lehmer_states[j] = mod_mul(lehmer_states[j-1], LEH_JUMP);
      return 1'b1;
   endfunction

   function automatic lehmer_rsp_type predict_rsp(lehmer_req_type r);
      lehmer_rsp_type res;
      int unsigned idx;
      logic [VAL_W-1:0] x;
      res = '0;
      idx = r.idx % NUM_STREAMS;
      if (r.cmd == CMD_PLANT) begin
         res.status = !plant_streams(r.seed);
      end else begin
         if (!streams_planted && idx != 0) void'(plant_streams(LEH_DEFAULT));
         case (r.cmd)
            CMD_DRAW: begin
               lehmer_states[idx] = mod_mul(lehmer_states[idx], LEH_MUL);
               res.value = lehmer_states[idx];
            end
            CMD_PUT: begin
               x = seed_reduce(r.seed);
               if (x == '0) res.status = 1'b1;
               else lehmer_states[idx] = x;
            end
            default: begin
               res.value = lehmer_states[idx];
            end
         endcase
      end
      return res;
   endfunction

   task automatic add_req(cmd_type cmd, logic [7:0] idx, logic [VAL_W-1:0] seed);
      lehmer_req_type it;
      it.cmd = cmd;
      it.idx = idx;
      it.seed = seed;
      it.drain = 1'b0;
      pending_reqs.push_back(it);
   endtask

   task automatic add_random_reqs(int unsigned count);
      lehmer_req_type it;
      int unsigned pick;
      for (int unsigned n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         it.seed = VAL_W'($urandom);
         case ($urandom_range(9))
            0: it.idx = 8'd0;
            1: it.idx = 8'hFF;
            default: it.idx = 8'($urandom_range(255));
         endcase
         if (pick < 40) it.cmd = CMD_DRAW;
         else if (pick < 68) it.cmd = CMD_READ;
         else if (pick < 98) it.cmd = CMD_PUT;
         else it.cmd = CMD_PLANT;
         if (it.cmd == CMD_PUT || it.cmd == CMD_PLANT) begin
            case ($urandom_range(15))
               0: it.seed = '0;
               1: it.seed = LEH_MOD;
               2: it.seed = VAL_W'($urandom_range(1, 16));
               3: it.seed = LEH_MOD - 1;
               default: ;
            endcase
         end
         it.drain = ($urandom_range(99) == 0);
         pending_reqs.push_back(it);
      end
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_taken != req_sent || rsp_expect.size() != 0)
         @(posedge clock);
   endtask

   // driver: one new item once the previous one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (req_taken == req_sent) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(pending_reqs[0].drain && rsp_expect.size() != 0)) begin
               drive_item = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_cmd <= drive_item.cmd;
               req_stream_index <= drive_item.idx;
               req_seed_value <= drive_item.seed;
               req_sent++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check results, predict on accepted items
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_expect.size() == 0) begin
               $error("unexpected item: value %0d status %0d", rsp_value, rsp_status);
               err_count++;
            end else begin
               got_expect = rsp_expect.pop_front();
               if (rsp_value !== got_expect.value) begin
                  $error("value: expected %0d, got %0d", got_expect.value, rsp_value);
                  err_count++;
               end
               if (rsp_status !== got_expect.status) begin
                  $error("status: expected %0d, got %0d", got_expect.status, rsp_status);
                  err_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            taken_item.cmd = cmd_type'(req_cmd);
            taken_item.idx = req_stream_index;
            taken_item.seed = req_seed_value;
            taken_item.drain = 1'b0;
            rsp_expect.push_back(predict_rsp(taken_item));
            req_taken++;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_multi_stream_lehmer_rng: errors");
      $finish;
   end

   initial begin
      for (int j = 0; j < NUM_STREAMS; j++) lehmer_states[j] = '0;
      lehmer_states[0] = LEH_DEFAULT;
      streams_planted = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 25;
      recv_idle_pct = 80;
      // unplanted: stream 0 is used directly
      add_req(CMD_READ, 8'd0, LEH_MOD);
      add_req(CMD_DRAW, 8'd0, '0);
      add_req(CMD_PUT, 8'd0, '0);
      add_req(CMD_PUT, 8'd0, 31'd5);
      add_req(CMD_READ, 8'd0, '0);
      // nonzero stream plants the default first; rejected seed leaves that plant
      add_req(CMD_PUT, 8'd17, LEH_MOD);
      add_req(CMD_READ, 8'd17, '0);
      add_req(CMD_READ, 8'd0, '0);
      // plant ignores the index; zero seeds are refused
      add_req(CMD_PLANT, 8'd9, '0);
      add_req(CMD_PLANT, 8'd9, LEH_MOD);
      add_req(CMD_READ, 8'hFF, '0);
      add_req(CMD_PLANT, 8'hFF, 31'd1);
      add_req(CMD_READ, 8'hFF, LEH_MOD);
      add_req(CMD_READ, 8'd1, '0);
      add_req(CMD_DRAW, 8'hFF, LEH_MOD);
      add_req(CMD_PLANT, 8'd3, LEH_MOD - 1);
      add_req(CMD_DRAW, 8'd0, '0);
      add_req(CMD_DRAW, 8'd128, '0);
      add_req(CMD_PUT, 8'hFF, LEH_MOD - 1);
      add_req(CMD_READ, 8'hFF, '0);
      add_req(CMD_DRAW, 8'hFF, '0);
      add_req(CMD_PUT, 8'd1, 31'd1);
      add_req(CMD_DRAW, 8'd1, '0);
      add_req(CMD_READ, 8'd254, '0);
      wait_drained();

      add_random_reqs(PHASE_ITEMS);
      wait_drained();
      send_idle_pct = 80;
      recv_idle_pct = 25;
      add_random_reqs(PHASE_ITEMS);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_reqs(PHASE_ITEMS);
      wait_drained();

      repeat (20) @(posedge clock);
      if (err_count == 0) begin
         $display("tb_multi_stream_lehmer_rng: clean");
      end else begin
         $display("tb_multi_stream_lehmer_rng: errors");
      end
      $finish;
   end

endmodule

/* multi_stream_lehmer_rng.f */
rtl/core/lehrng_pkg.sv
rtl/core/lehrng_ram.sv
rtl/core/lehrng_ctrl.sv
rtl/core/lehrng_dp.sv
rtl/core/multi_stream_lehmer_rng.sv
tb/tb_multi_stream_lehmer_rng.sv
